@@ rtl/pixel_format_converter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_CORE_MACROS_SVH
`define PIXEL_FORMAT_CONVERTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Format codes, register indexes and the conversion request type.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  // Source format codes
  localparam logic [2:0] SF_RGB555   = 3'd0;
  localparam logic [2:0] SF_RGB888   = 3'd1;
  localparam logic [2:0] SF_ARGB8888 = 3'd2;
  localparam logic [2:0] SF_INDEX8   = 3'd3;
  localparam logic [2:0] SF_INDEX4   = 3'd4;
  localparam logic [2:0] SF_INDEX2   = 3'd5;
  localparam logic [2:0] SF_INDEX1   = 3'd6;

  // Destination format codes
  localparam logic [1:0] DF_RGB555   = 2'd0;
  localparam logic [1:0] DF_RGB888   = 2'd1;
  localparam logic [1:0] DF_ARGB8888 = 2'd2;

  // Item kinds
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Register indexes (byte address bit 2)
  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_DEST_FORMAT   = 1'b1;

  // Conversion constants
  localparam logic [31:0] ALPHA_OPAQUE   = 32'hFF00_0000;
  localparam logic [15:0] PAL_COLOR_MASK = 16'h7BDE;
  localparam logic [15:0] PAL_TRANS_FLAG = 16'h8000;
  localparam logic [15:0] PAL_ALPHA_B7   = 16'h0200;
  localparam logic [15:0] PAL_ALPHA_B6   = 16'h0040;
  localparam logic [15:0] PAL_ALPHA_B5   = 16'h0001;
  localparam logic [7:0]  ALPHA_KEEP     = 8'd240;

  // One conversion job: formats, raw pixel data and palette entry
  typedef struct packed {
    logic [2:0]  src_fmt;
    logic [1:0]  dst_fmt;
    logic [31:0] data;
    logic [31:0] pal_color;
  } conv_req_t;

  function automatic logic is_packed(input logic [2:0] sf);
    return (sf == SF_INDEX4) || (sf == SF_INDEX2) || (sf == SF_INDEX1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/pixel_format_converter_core.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter_core
// Streaming converter from RGB555/RGB888/ARGB8888/palette indices to
// RGB555/RGB888/ARGB8888, with a palette loaded through the input stream.
// ----------------------------------------------------------------------------
// A new input item is taken every cycle while stage 1 can finish its item.
// Palette writes never wait for stage 2; direct and 8-bit index pixels issue
// one lookup each, and a packed index byte (4, 2 or 1 bit indices) holds the
// input until every index it carries (pixel_count, clamped to 2, 4 or 8) has
// issued, since the palette has a single read port used once per cycle. A
// result moves from the stage 1 hold through stage 2 to the output register.
// The palette needs no clearing pass after reset: entries must be written
// before they are looked up.
`default_nettype none
`include "pixel_format_converter_core_macros.svh"

module pixel_format_converter_core
  import pfc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: pal_index[7:0], pal_color[39:8], pixel_data[71:40],
  //        pixel_count[75:72], zero pad [79:76]
  input  wire logic [79:0] in_tdata,
  // tuser: op[0]
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: pixel_out[31:0]
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int         PAL_AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] PAL_DEPTH_W = 9'(PALETTE_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] src_fmt_r;
  logic [1:0] dst_fmt_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SF_RGB555;
      dst_fmt_r <= DF_RGB555;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SOURCE_FORMAT: src_fmt_r <= cfg_pwdata[2:0];
        REG_DEST_FORMAT:   dst_fmt_r <= cfg_pwdata[1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SOURCE_FORMAT: cfg_prdata = {29'd0, src_fmt_r};
      REG_DEST_FORMAT:   cfg_prdata = {30'd0, dst_fmt_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [7:0]  in_pal_index;
  logic [31:0] in_pal_color;
  logic [31:0] in_pixel_data;
  logic [3:0]  in_pixel_count;
  logic [3:0]  in_cap;
  logic [3:0]  in_count;
  logic        in_emit;
  logic        in_fire;

  assign in_pal_index   = in_tdata[7:0];
  assign in_pal_color   = in_tdata[39:8];
  assign in_pixel_data  = in_tdata[71:40];
  assign in_pixel_count = in_tdata[75:72];
  assign in_fire        = in_tvalid && in_tready;

  always_comb begin
    case (src_fmt_r)
      SF_INDEX4: in_cap = 4'd2;
      SF_INDEX2: in_cap = 4'd4;
      SF_INDEX1: in_cap = 4'd8;
      default:   in_cap = 4'd1;
    endcase
    if (!is_packed(src_fmt_r)) begin
      in_count = 4'd1;
    end else if (in_pixel_count > in_cap) begin
      in_count = in_cap;
    end else begin
      in_count = in_pixel_count;
    end
    in_emit = (in_tuser == OP_PIXEL) && (src_fmt_r <= SF_INDEX1) &&
              (dst_fmt_r <= DF_ARGB8888) && (in_count != 4'd0);
  end

  // --------------------------------------------------------------------------
  // Stage 1: item hold and index unpack
  // --------------------------------------------------------------------------
  logic        u_valid_r;
  logic        u_op_r;
  logic        u_emit_r;
  logic [7:0]  u_pal_index_r;
  logic [31:0] u_pal_color_r;
  logic [31:0] u_data_r;
  logic [3:0]  u_count_r;
  logic [2:0]  u_pos_r;

  logic        s2_ready;
  logic        s1_last;
  logic        s1_issue;
  logic        s1_done;
  logic [2:0]  lk_shift;
  logic [7:0]  lk_byte;
  logic [7:0]  lk_idx;
  logic        lk_oob;
  logic        pal_wr;

  assign s1_last   = (({1'b0, u_pos_r}) + 4'd1) == u_count_r;
  assign s1_issue  = u_valid_r && u_emit_r && s2_ready;
  assign s1_done   = u_valid_r && (!u_emit_r || (s2_ready && s1_last));
  assign in_tready = !u_valid_r || s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_valid_r <= 1'b0;
      u_pos_r   <= 3'd0;
    end else if (in_fire) begin
      u_valid_r <= 1'b1;
      u_pos_r   <= 3'd0;
    end else if (s1_done) begin
      u_valid_r <= 1'b0;
    end else if (s1_issue) begin
      u_pos_r <= u_pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      u_op_r        <= in_tuser;
      u_emit_r      <= in_emit;
      u_pal_index_r <= in_pal_index;
      u_pal_color_r <= in_pal_color;
      u_data_r      <= in_pixel_data;
      u_count_r     <= in_count;
    end
  end

  // Pick the next index, most significant first
  always_comb begin
    case (src_fmt_r)
      SF_INDEX4: lk_shift = {u_pos_r[0], 2'b00};
      SF_INDEX2: lk_shift = {u_pos_r[1:0], 1'b0};
      SF_INDEX1: lk_shift = u_pos_r;
      default:   lk_shift = 3'd0;
    endcase
    lk_byte = u_data_r[7:0] << lk_shift;
    case (src_fmt_r)
      SF_INDEX4: lk_idx = {4'd0, lk_byte[7:4]};
      SF_INDEX2: lk_idx = {6'd0, lk_byte[7:6]};
      SF_INDEX1: lk_idx = {7'd0, lk_byte[7]};
      default:   lk_idx = u_data_r[7:0];
    endcase
    lk_oob = {1'b0, lk_idx} >= PAL_DEPTH_W;
  end

  assign pal_wr = u_valid_r && (u_op_r == OP_PALETTE) &&
                  ({1'b0, u_pal_index_r} < PAL_DEPTH_W);

  // --------------------------------------------------------------------------
  // Palette memory
  // --------------------------------------------------------------------------
  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] pal_rdata_r;

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[u_pal_index_r[PAL_AW-1:0]] <= u_pal_color_r;
    end
    if (s1_issue) begin
      pal_rdata_r <= pal_mem[lk_idx[PAL_AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: lookup result and conversion
  // --------------------------------------------------------------------------
  logic        s2_valid_r;
  logic        s2_last_r;
  logic        s2_oob_r;
  logic [31:0] s2_data_r;
  logic        s2_fire;
  logic        out_ready;
  conv_req_t   conv_req;
  logic [31:0] conv_pixel;

  assign out_ready = !out_tvalid || out_tready;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s2_fire   = s2_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_issue) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_issue) begin
      s2_last_r <= s1_last;
      s2_oob_r  <= lk_oob;
      s2_data_r <= u_data_r;
    end
  end

  assign conv_req.src_fmt   = src_fmt_r;
  assign conv_req.dst_fmt   = dst_fmt_r;
  assign conv_req.data      = s2_data_r;
  assign conv_req.pal_color = s2_oob_r ? 32'd0 : pal_rdata_r;

  pfc_convert u_convert (
    .req   (conv_req),
    .pixel (conv_pixel)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic        out_valid_r;
  logic [31:0] out_pixel_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_pixel_r <= conv_pixel;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PFC_ASSERT_SAME(a_pos_in_range, u_valid_r && u_emit_r, ({1'b0, u_pos_r}) < u_count_r, "unpack position past item count")
  `PFC_ASSERT_SAME(a_issue_is_pixel, s1_issue, (u_op_r == OP_PIXEL) && !pal_wr, "palette write issued as lookup")
  `PFC_ASSERT_NEXT(a_issue_fills_s2, s1_issue, s2_valid_r, "lookup lost between stages")
  `PFC_ASSERT_NEXT(a_s2_fills_out, s2_fire, out_valid_r, "converted pixel lost before output")

endmodule

`default_nettype wire

@@ rtl/pfc_convert.sv @@
// ----------------------------------------------------------------------------
// pfc_convert
// Combinational conversion of one pixel or palette entry to the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_convert
  import pfc_pkg::*;
(
  input  conv_req_t   req,
  output logic [31:0] pixel
);

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [15:0] to_555(input logic [31:0] c);
    return {1'b0, c[23:19], c[15:11], c[7:3]};
  endfunction

  function automatic logic [15:0] pal_555(input logic [31:0] c);
    logic [15:0] v;
    v = to_555(c);
    if (c[31:24] < ALPHA_KEEP) begin
      v = (v & PAL_COLOR_MASK) | PAL_TRANS_FLAG;
      if (c[31]) v = v | PAL_ALPHA_B7;
      if (c[30]) v = v | PAL_ALPHA_B6;
      if (c[29]) v = v | PAL_ALPHA_B5;
    end
    return v;
  endfunction

  function automatic logic [31:0] from_555(input logic [15:0] v, input logic [1:0] df);
    logic [31:0] rgb;
    rgb = {8'h00, expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0])};
    case (df)
      DF_RGB555:   return {16'h0000, v};
      DF_ARGB8888: return rgb | ALPHA_OPAQUE;
      default:     return rgb;
    endcase
  endfunction

  function automatic logic [31:0] from_32(input logic [31:0] v, input logic [1:0] df);
    case (df)
      DF_RGB555: return {16'h0000, to_555(v)};
      DF_RGB888: return {8'h00, v[23:0]};
      default:   return v;
    endcase
  endfunction

  always_comb begin
    case (req.src_fmt)
      SF_RGB555:   pixel = from_555(req.data[15:0], req.dst_fmt);
      SF_RGB888:   pixel = from_32({8'hFF, req.data[23:0]}, req.dst_fmt);
      SF_ARGB8888: pixel = from_32(req.data, req.dst_fmt);
      SF_INDEX8: begin
        if (req.dst_fmt == DF_RGB555) begin
          pixel = {16'h0000, pal_555(req.pal_color)};
        end else begin
          pixel = from_32(req.pal_color, req.dst_fmt);
        end
      end
      // packed indices always pass through the 555 palette form
      default:     pixel = from_555(pal_555(req.pal_color), req.dst_fmt);
    endcase
  end

endmodule

`default_nettype wire

@@ sim/tb_pixel_format_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_pixel_format_converter_core
// Streams palette loads and pixels through the converter under a range of source
// and destination format pairs, predicts each converted pixel in the bench
// and compares every output transfer in order, with random idle and stall.
// ----------------------------------------------------------------------------
module tb_pixel_format_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic        op;
    logic [7:0]  pal_index;
    logic [31:0] pal_color;
    logic [31:0] pixel_data;
    logic [3:0]  pixel_count;
  } stream_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } pixel_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Bench copy of the converter state
  logic [2:0]  cur_src = SF_RGB555;
  logic [1:0]  cur_dst = DF_RGB555;
  logic [31:0] palette_copy [256];
  bit          palette_written [256];
  logic [7:0]  written_list [$];

  pixel_result_t pending_pixels [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  pixel_format_converter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [15:0] rgb_to_555(input logic [31:0] c);
    return {1'b0, c[23:19], c[15:11], c[7:3]};
  endfunction

  function automatic logic [15:0] palette_word_555(input logic [31:0] c);
    logic [15:0] v;
    v = rgb_to_555(c);
    if (c[31:24] < ALPHA_KEEP) begin
      // translucent entry: drop color low bits, carry alpha bits instead
      v = (v & PAL_COLOR_MASK) | PAL_TRANS_FLAG;
      if (c[31]) v = v | PAL_ALPHA_B7;
      if (c[30]) v = v | PAL_ALPHA_B6;
      if (c[29]) v = v | PAL_ALPHA_B5;
    end
    return v;
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [31:0] expand_555(input logic [15:0] v, input logic [1:0] df);
    logic [31:0] rgb;
    if (df == DF_RGB555) return {16'h0000, v};
    rgb = {8'h00, widen5(v[14:10]), widen5(v[9:5]), widen5(v[4:0])};
    if (df == DF_ARGB8888) rgb = rgb | ALPHA_OPAQUE;
    return rgb;
  endfunction

  function automatic logic [31:0] reduce_32(input logic [31:0] v, input logic [1:0] df);
    if (df == DF_RGB555) return {16'h0000, rgb_to_555(v)};
    if (df == DF_RGB888) return {8'h00, v[23:0]};
    return v;
  endfunction

  function automatic int packed_width(input logic [2:0] sf);
    return (sf == SF_INDEX4) ? 4 : (sf == SF_INDEX2) ? 2 : 1;
  endfunction

  task automatic expect_pixel(input logic [31:0] pixel, input logic last);
    pixel_result_t r;
    r.pixel = pixel;
    r.last  = last;
    pending_pixels.push_back(r);
  endtask

  task automatic predict_item(input stream_item_t it);
    logic [31:0] entry;
    logic [7:0]  idx;
    int width;
    int cap;
    int n;
    int shift;
    if (it.op == OP_PALETTE) begin
      palette_copy[it.pal_index] = it.pal_color;
      if (!palette_written[it.pal_index]) begin
        palette_written[it.pal_index] = 1'b1;
        written_list.push_back(it.pal_index);
      end
      return;
    end
    if (cur_dst > DF_ARGB8888 || cur_src > SF_INDEX1) return;
    case (cur_src)
      SF_RGB555: begin
        expect_pixel(expand_555(it.pixel_data[15:0], cur_dst), 1'b1);
      end
      SF_RGB888: begin
        expect_pixel(reduce_32(ALPHA_OPAQUE | {8'h00, it.pixel_data[23:0]}, cur_dst), 1'b1);
      end
      SF_ARGB8888: begin
        expect_pixel(reduce_32(it.pixel_data, cur_dst), 1'b1);
      end
      SF_INDEX8: begin
        entry = palette_copy[it.pixel_data[7:0]];
        if (cur_dst == DF_RGB555) expect_pixel({16'h0000, palette_word_555(entry)}, 1'b1);
        else expect_pixel(reduce_32(entry, cur_dst), 1'b1);
      end
      default: begin
        width = packed_width(cur_src);
        cap   = 8 / width;
        n     = (int'(it.pixel_count) > cap) ? cap : int'(it.pixel_count);
        // unpack MSB first, each index through the 555 palette form
        for (int i = 0; i < n; i++) begin
          shift = 8 - width * (i + 1);
          idx   = (it.pixel_data[7:0] >> shift) & ((8'd1 << width) - 8'd1);
          expect_pixel(expand_555(palette_word_555(palette_copy[idx]), cur_dst), i + 1 == n);
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h last %b", $realtime, out_tdata, out_tlast);
        error_count = error_count + 1;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          $display("%0t: pixel expected %h got %h", $realtime, want.pixel, out_tdata);
          error_count = error_count + 1;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %b got %b", $realtime, want.last, out_tlast);
          error_count = error_count + 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  task automatic send_item(input stream_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {4'h0, it.pixel_count, it.pixel_data, it.pal_color, it.pal_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(it);
  endtask

  // Hold the stream until every predicted pixel has arrived and the pipe is empty
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_formats(input logic [2:0] sf, input logic [1:0] df);
    logic [31:0] upper;
    wait_for_drain();
    // unused upper data bits must be ignored
    upper = $urandom();
    cfg_write(REG_SOURCE_FORMAT, {upper[31:3], sf});
    upper = $urandom();
    cfg_write(REG_DEST_FORMAT, {upper[31:2], df});
    cur_src = sf;
    cur_dst = df;
  endtask

  function automatic stream_item_t palette_item(input logic [7:0] idx, input logic [31:0] color);
    stream_item_t it;
    it.op          = OP_PALETTE;
    it.pal_index   = idx;
    it.pal_color   = color;
    it.pixel_data  = $urandom();
    it.pixel_count = 4'($urandom_range(15));
    return it;
  endfunction

  function automatic stream_item_t pixel_item(input logic [31:0] data, input logic [3:0] count);
    logic [31:0] noise;
    stream_item_t it;
    noise          = $urandom();
    it.op          = OP_PIXEL;
    it.pal_index   = noise[7:0];
    it.pal_color   = $urandom();
    it.pixel_data  = data;
    it.pixel_count = count;
    return it;
  endfunction

  function automatic logic [31:0] random_color();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(3))
      0: c[31:24] = 8'($urandom_range(255, 240));
      1: c[31:24] = 8'($urandom_range(239, 224));
      default: ;
    endcase
    return c;
  endfunction

  function automatic stream_item_t random_pixel();
    logic [31:0] data;
    logic [3:0]  count;
    int cap;
    int r;
    data  = $urandom();
    count = 4'($urandom_range(15));
    // index8 lookups only touch entries that have been loaded
    if (cur_src == SF_INDEX8)
      data[7:0] = written_list[$urandom_range(written_list.size() - 1)];
    if (cur_src >= SF_INDEX4 && cur_src <= SF_INDEX1) begin
      cap = 8 / packed_width(cur_src);
      r   = $urandom_range(9);
      if (r == 0) count = 4'd0;
      else if (r == 1) count = 4'($urandom_range(15, cap + 1));
      else count = 4'($urandom_range(cap, 1));
    end
    return pixel_item(data, count);
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_palette_load();
    logic [7:0]  alpha_set [8] = '{8'h00, 8'h20, 8'h40, 8'h80, 8'hE0, 8'hEF, 8'hF0, 8'hFF};
    logic [31:0] color;
    // entries 0..15 cover every packed index; alpha walks across the 240 boundary
    for (int i = 0; i < 16; i++) begin
      color = random_color();
      if (i < 8) color[31:24] = alpha_set[i];
      if (i == 0) color[23:0] = 24'h000000;
      if (i == 7 || i == 6) color[23:0] = 24'hFFFFFF;
      send_item(palette_item(8'(i), color));
    end
    send_item(palette_item(8'd255, 32'hFFFF_FFFF));
    send_item(palette_item(8'd254, 32'h00FF_FFFF));
  endtask

  task automatic test_direct_formats();
    logic [31:0] data;
    for (int sf = 0; sf <= 2; sf++) begin
      for (int df = 0; df <= 2; df++) begin
        set_formats(3'(sf), 2'(df));
        data = (df == 0) ? 32'hFFFF_FFFF : (df == 1) ? 32'h0000_0000 : 32'h8421_7BDE;
        send_item(pixel_item(data, 4'($urandom_range(15))));
      end
    end
  endtask

  task automatic test_index_formats();
    logic [31:0] upper;
    for (int df = 0; df <= 2; df++) begin
      set_formats(SF_INDEX8, 2'(df));
      upper = $urandom();
      send_item(pixel_item({upper[31:8], 8'd255}, 4'd0));
      send_item(pixel_item({upper[31:8], 8'd254}, 4'd15));
      send_item(pixel_item({upper[31:8], 8'(4 + df)}, 4'd1));
    end
    set_formats(SF_INDEX4, DF_ARGB8888);
    send_item(pixel_item(32'hFFFF_FFA5, 4'd2));
    send_item(pixel_item(32'h0000_00C3, 4'd0));
    set_formats(SF_INDEX2, DF_RGB888);
    send_item(pixel_item(32'h0000_001B, 4'd4));
    send_item(pixel_item(32'hFFFF_FFE4, 4'd15));
    set_formats(SF_INDEX1, DF_RGB555);
    send_item(pixel_item(32'h0000_00A5, 4'd8));
    send_item(pixel_item(32'h0000_00FF, 4'd3));
    send_item(pixel_item(32'h0000_0001, 4'd9));
  endtask

  task automatic test_unused_formats();
    set_formats(3'd7, DF_RGB555);
    send_item(pixel_item($urandom(), 4'd4));
    // palette writes still land while the source format is unused
    send_item(palette_item(8'd200, 32'h1234_5678));
    send_item(pixel_item($urandom(), 4'd8));
    set_formats(SF_RGB555, 2'd3);
    send_item(pixel_item($urandom(), 4'd1));
    set_formats(SF_INDEX8, DF_ARGB8888);
    send_item(pixel_item(32'h0000_00C8, 4'd1));
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    logic [2:0] sf;
    logic [1:0] df;
    logic [7:0] idx;
    int sent;
    int seg;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      sf = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
      df = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      set_formats(sf, df);
      seg = $urandom_range(30, 10);
      for (int k = 0; k < seg && sent < n_items; k++) begin
        if ($urandom_range(99) < 15) begin
          idx = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
          send_item(palette_item(idx, random_color()));
          sent++;
        end else begin
          send_item(random_pixel());
          if (cur_src <= SF_INDEX1 && cur_dst <= DF_ARGB8888) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_direct_formats();
    test_index_formats();
    test_unused_formats();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 57, 0);
    test_random_traffic(60, 0, 57);
    test_random_traffic(60, 11, 11);
    wait_for_drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfc_pkg.sv
rtl/pfc_convert.sv
rtl/pixel_format_converter_core.sv
sim/tb_pixel_format_converter_core.sv
